FILE: rtl/core/fqs_pkg.sv
// types and codes shared by the queue-with-search block
`timescale 1ns / 1ps
package fqs_pkg;

	localparam logic [1:0] MODE_ENQ    = 2'd0;
	localparam logic [1:0] MODE_DEQ    = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;
	localparam logic [1:0] MODE_LIST   = 2'd3;

	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_EMPTY    = 3'd1;
	localparam logic [2:0] STATUS_FULL     = 3'd2;
	localparam logic [2:0] STATUS_FOUND    = 3'd3;
	localparam logic [2:0] STATUS_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] data_value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] result_value;
		logic               last;
	} rsp_t;

endpackage

FILE: rtl/core/fqs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/fifo_queue_with_search.sv
// bounded fifo of signed words with head-to-tail search and listing
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  fqs_pkg::req_t (mode, data_value)
//   rsp      out  rsp_valid/rsp_stall  fqs_pkg::rsp_t (status, result_value, last)
//
// enqueue, dequeue and any empty/full refusal are answered from the idle state.
// search and list walk the stored entries through the ram read port, one entry
// per cycle unless a stalled rsp beat holds it; list returns one beat each.
// reset clears head, tail and occupancy; the entry ram holds no reset value.
// a stalled rsp beat holds the walk; req is stalled while a walk is running.
`timescale 1ns / 1ps
module fifo_queue_with_search #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fqs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fqs_pkg::rsp_t rsp
);
	import fqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LIST
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  tail_q;
	logic [CW-1:0]  occ_q;
	logic [AW-1:0]  cur_q;
	logic [AW-1:0]  cnt_q;
	logic [31:0]    key_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	logic           acc;
	logic           out_free;
	logic           is_full;
	logic           is_empty;
	logic           walk_last;
	logic           hit;
	logic           adv;
	logic           we;
	logic [AW-1:0]  rd_addr;
	logic [31:0]    rd_data;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
		nxt = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
	endfunction

	fqs_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(tail_q),
		.wdata(req.data_value),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		out_free  = !rsp_valid_q || !rsp_stall;
		req_stall = !((state_q == ST_IDLE) && out_free);
		acc       = req_valid && !req_stall;
		is_full   = (occ_q == CW'(DEPTH));
		is_empty  = (occ_q == '0);
		walk_last = ((CW'(cnt_q) + CW'(1)) == occ_q);
		hit       = (rd_data == key_q);
		we        = acc && (req.mode == MODE_ENQ) && !is_full;
		case (state_q)
			ST_SEARCH: adv = !hit && !walk_last;
			ST_LIST:   adv = out_free && !walk_last;
			default:   adv = 1'b0;
		endcase
		// rd_data always holds the entry at cur_q while walking
		if (state_q == ST_IDLE) begin
			rd_addr = head_q;
		end else if (adv) begin
			rd_addr = nxt(cur_q);
		end else begin
			rd_addr = cur_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.result_value <= '0;
						rsp_q.last         <= 1'b1;
						case (req.mode)
							MODE_ENQ: begin
								if (is_full) begin
									rsp_q.status <= STATUS_FULL;
								end else begin
									rsp_q.status <= STATUS_OK;
									tail_q       <= nxt(tail_q);
									occ_q        <= occ_q + CW'(1);
								end
							end
							MODE_DEQ: begin
								if (is_empty) begin
									rsp_q.status <= STATUS_EMPTY;
								end else begin
									rsp_q.status <= STATUS_OK;
									head_q       <= nxt(head_q);
									occ_q        <= occ_q - CW'(1);
								end
							end
							MODE_SEARCH, MODE_LIST: begin
								if (is_empty) begin
									rsp_q.status <= STATUS_EMPTY;
								end else begin
									// no beat yet, the walk produces it
									rsp_valid_q <= 1'b0;
									key_q       <= req.data_value;
									cur_q       <= head_q;
									cnt_q       <= '0;
									state_q     <= (req.mode == MODE_SEARCH) ? ST_SEARCH
									                                         : ST_LIST;
								end
							end
							default: begin
								rsp_q.status <= STATUS_EMPTY;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (hit || walk_last) begin
						if (out_free) begin
							rsp_valid_q        <= 1'b1;
							rsp_q.status       <= hit ? STATUS_FOUND : STATUS_NOTFOUND;
							rsp_q.result_value <= hit ? rd_data : '0;
							rsp_q.last         <= 1'b1;
							state_q            <= ST_IDLE;
						end
					end else begin
						cur_q <= nxt(cur_q);
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_LIST: begin
					if (out_free) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.status       <= STATUS_OK;
						rsp_q.result_value <= rd_data;
						rsp_q.last         <= walk_last;
						if (walk_last) begin
							state_q <= ST_IDLE;
						end else begin
							cur_q <= nxt(cur_q);
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
